[src/sad_pkg.sv]
// ----------------------------------------------------------------------------
// sad_pkg: shared types and constants for the servo angle to duty mapper
// Holds field widths, calibration reset values, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package sad_pkg;

   localparam int ANGLE_W = 17;
   localparam int DUTY_W  = 16;
   localparam int ADDR_W  = 2;
   localparam int REQ_TDATA_W = 24;

   localparam int PROD_W = 35;
   localparam int ACC_W  = 36;
   localparam int DVD_W  = 35;
   localparam int REM_W  = 18;
   localparam int CNT_W  = 4;

   localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 17'sd0;
   localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 17'sd18000;
   localparam logic [DUTY_W-1:0]  MIN_DUTY_RST  = 16'd1638;
   localparam logic [DUTY_W-1:0]  MAX_DUTY_RST  = 16'd8192;

   localparam logic [ADDR_W-1:0] REG_MIN_ANGLE = 2'd0;
   localparam logic [ADDR_W-1:0] REG_MAX_ANGLE = 2'd1;
   localparam logic [ADDR_W-1:0] REG_MIN_DUTY  = 2'd2;
   localparam logic [ADDR_W-1:0] REG_MAX_DUTY  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_MUL_BASE,
      ST_MUL_SLOPE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_DONE
   } seq_state_type;

endpackage

[src/servo_angle_to_duty.sv]
// ----------------------------------------------------------------------------
// servo_angle_to_duty: map a servo angle request to a PWM compare level
// Clamps the request to the calibration range, drops repeats, and computes
// the linear duty with a shared multiplier and a 16-step restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one angle request per transaction (signed centidegrees).
//   rsp_* carries one duty level per transaction; a request whose clamped
//   angle equals the last accepted one produces no transaction at all.
//   csr_* writes the four calibration registers; any write also forgets the
//   last angle so the next request always produces a duty level. Write only
//   while the block is idle.
// Sequence:
//   One request at a time. A full request runs clamp, two shared-multiplier
//   passes, accumulate, 16 divider steps and the output load; rsp_tvalid rises
//   and the input reopens together, once the output register is free. A
//   repeated angle frees the input straight after clamp, a zero calibration
//   span after the output load. The divider loop sets the rate.
// Reset:
//   Synchronous, active high. Restores calibration defaults, clears the
//   last-angle memory and drops any pending result.
// Stall:
//   A finished result waits in the output register; the next request may be
//   taken and worked on meanwhile, and it holds in its final state until the
//   output register frees.
// ----------------------------------------------------------------------------
module servo_angle_to_duty
   import sad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [16:0] angle_request, [23:17] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DUTY_W-1:0]      rsp_tdata,   // [15:0] duty_level
   input  logic                   csr_we,
   input  logic [ADDR_W-1:0]      csr_addr,
   input  logic [ANGLE_W-1:0]     csr_wdata
);

   // control state
   seq_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic last_valid_ff, last_valid_in;

   // calibration registers
   logic signed [ANGLE_W-1:0] min_angle_ff, min_angle_in;
   logic signed [ANGLE_W-1:0] max_angle_ff, max_angle_in;
   logic [DUTY_W-1:0] min_duty_ff, min_duty_in;
   logic [DUTY_W-1:0] max_duty_ff, max_duty_in;

   // datapath registers
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [ANGLE_W-1:0] last_angle_ff, last_angle_in;
   logic [ANGLE_W-1:0] den_abs_ff, den_abs_in;
   logic [ANGLE_W-1:0] diff_abs_ff, diff_abs_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DUTY_W-1:0] quo_ff, quo_in;
   logic [DUTY_W-1:0] rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic signed [ANGLE_W-1:0] lo_angle, hi_angle, clamped;
   logic signed [ANGLE_W:0] den_s, diff_s;
   logic signed [ANGLE_W:0] mul_a;
   logic signed [ANGLE_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [ACC_W-1:0] sum;
   logic [DVD_W-1:0] dividend;
   logic [REM_W-1:0] divisor;
   logic [REM_W:0] trial, trial_diff;
   logic is_repeat, span_zero, out_free;

   // ---------------------------------------------------------------------
   // Clamp and span
   // ---------------------------------------------------------------------
   always_comb begin
      if (min_angle_ff < max_angle_ff) begin
         lo_angle = min_angle_ff;
         hi_angle = max_angle_ff;
      end else begin
         lo_angle = max_angle_ff;
         hi_angle = min_angle_ff;
      end
      if (angle_ff < lo_angle) begin
         clamped = lo_angle;
      end else if (angle_ff > hi_angle) begin
         clamped = hi_angle;
      end else begin
         clamped = angle_ff;
      end
      den_s  = {max_angle_ff[ANGLE_W-1], max_angle_ff} - {min_angle_ff[ANGLE_W-1], min_angle_ff};
      diff_s = {clamped[ANGLE_W-1], clamped} - {min_angle_ff[ANGLE_W-1], min_angle_ff};
      // |diff| never exceeds |den| <= 131071, so both fit in 17 unsigned bits
      den_abs_in  = den_s[ANGLE_W]  ? ANGLE_W'(-den_s)  : den_s[ANGLE_W-1:0];
      diff_abs_in = diff_s[ANGLE_W] ? ANGLE_W'(-diff_s) : diff_s[ANGLE_W-1:0];
      is_repeat = last_valid_ff && (clamped == last_angle_ff);
      span_zero = (den_s == '0);
   end

   // ---------------------------------------------------------------------
   // Shared multiplier: base term min_duty*|den|, then slope term
   // |clamped-min_angle| * (max_duty-min_duty)
   // ---------------------------------------------------------------------
   always_comb begin
      if (state_ff == ST_MUL_BASE) begin
         mul_a = {1'b0, den_abs_ff};
         mul_b = {1'b0, min_duty_ff};
      end else begin
         mul_a = {1'b0, diff_abs_ff};
         mul_b = {1'b0, max_duty_ff} - {1'b0, min_duty_ff};
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // ---------------------------------------------------------------------
   // Rounding dividend 2*T + |den| over divisor 2*|den|; quotient < 2^16
   // ---------------------------------------------------------------------
   always_comb begin
      sum        = acc_ff + {prod_ff[PROD_W-1], prod_ff};
      dividend   = {sum[DVD_W-2:0], 1'b0} + DVD_W'(den_abs_ff);
      divisor    = {den_abs_ff, 1'b0};
      trial      = {rem_ff, quo_ff[DUTY_W-1]};
      trial_diff = trial - {1'b0, divisor};
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            priority if (is_repeat) state_in = ST_IDLE;
            else if (span_zero)     state_in = ST_DONE;
            else                    state_in = ST_MUL_BASE;
         end
         ST_MUL_BASE:  state_in = ST_MUL_SLOPE;
         ST_MUL_SLOPE: state_in = ST_ACCUM;
         ST_ACCUM:     state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (count_ff == CNT_W'(DUTY_W - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Outputs and register next values
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;

      angle_in      = angle_ff;
      last_angle_in = last_angle_ff;
      last_valid_in = last_valid_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      count_in      = count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      min_angle_in  = min_angle_ff;
      max_angle_in  = max_angle_ff;
      min_duty_in   = min_duty_ff;
      max_duty_in   = max_duty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            angle_in = req_tdata[ANGLE_W-1:0];
         end
         ST_CLAMP: begin
            if (!is_repeat) begin
               last_angle_in = clamped;
               last_valid_in = 1'b1;
               // zero span: result is min_duty
               quo_in = min_duty_ff;
            end
         end
         ST_MUL_BASE: begin
            prod_in = mul_p;
         end
         ST_MUL_SLOPE: begin
            acc_in  = {prod_ff[PROD_W-1], prod_ff};
            prod_in = mul_p;
         end
         ST_ACCUM: begin
            rem_in   = dividend[DVD_W-2:DUTY_W];
            quo_in   = dividend[DUTY_W-1:0];
            count_in = '0;
         end
         ST_DIVIDE: begin
            // one restoring step: shift in a dividend bit, subtract if it fits
            if (!trial_diff[REM_W]) begin
               rem_in = trial_diff[REM_W-1:0];
               quo_in = {quo_ff[DUTY_W-2:0], 1'b1};
            end else begin
               rem_in = trial[REM_W-1:0];
               quo_in = {quo_ff[DUTY_W-2:0], 1'b0};
            end
            count_in = count_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = quo_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase

      // configuration write: update register, forget the last angle
      if (csr_we) begin
         last_valid_in = 1'b0;
         unique case (csr_addr)
            REG_MIN_ANGLE: min_angle_in = csr_wdata;
            REG_MAX_ANGLE: max_angle_in = csr_wdata;
            REG_MIN_DUTY:  min_duty_in  = csr_wdata[DUTY_W-1:0];
            REG_MAX_DUTY:  max_duty_in  = csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
         last_angle_ff <= '0;
         min_angle_ff  <= MIN_ANGLE_RST;
         max_angle_ff  <= MAX_ANGLE_RST;
         min_duty_ff   <= MIN_DUTY_RST;
         max_duty_ff   <= MAX_DUTY_RST;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_valid_ff <= last_valid_in;
         last_angle_ff <= last_angle_in;
         min_angle_ff  <= min_angle_in;
         max_angle_ff  <= max_angle_in;
         min_duty_ff   <= min_duty_in;
         max_duty_ff   <= max_duty_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      den_abs_ff  <= (state_ff == ST_CLAMP) ? den_abs_in  : den_abs_ff;
      diff_abs_ff <= (state_ff == ST_CLAMP) ? diff_abs_in : diff_abs_ff;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // divider remainder stays below the divisor while iterating
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < divisor)
      else $error("divider remainder out of range");

   // one request at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // configuration write forgets the last angle
   a_cfg_clears_last: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !last_valid_ff)
      else $error("last angle kept across configuration write");
`endif

endmodule
